>>> rtl/ales_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ales_pkg;

  localparam int OPCODE_W = 2;
  localparam int VERTEX_W = 10;

  typedef logic [OPCODE_W-1:0] opcode_t;
  typedef logic [VERTEX_W-1:0] vertex_t;

  localparam opcode_t OP_CLEAR = 2'd0;
  localparam opcode_t OP_ADD   = 2'd1;
  localparam opcode_t OP_QUERY = 2'd2;

endpackage

`default_nettype wire

>>> rtl/adjacency_list_edge_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Steps: an add writes its entry and the new list head; a query reads the head,
// then walks the list; a clear sweeps the head RAM; a dropped add, an unused
// opcode or an out-of-range query goes straight to its result.
// Throughput: one item at a time; a query is bounded by the edge RAM read port,
// one list entry per cycle. A new item may be taken while a result waits.
// Reset: synchronous, active low; afterwards a sweep clears every head RAM
// entry before the first item is taken.
module adjacency_list_edge_store #(
  parameter int VERTEX_COUNT  = 1024,
  parameter int EDGE_CAPACITY = 4096
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [ales_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [ales_pkg::VERTEX_W-1:0] in_from_vertex,
  input  logic [ales_pkg::VERTEX_W-1:0] in_to_vertex,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_is_answer,
  output logic                    out_edge_found,
  output logic                    out_overflow
);

  import ales_pkg::*;

  // address and count widths
  localparam int VW = $clog2(VERTEX_COUNT);
  localparam int EW = $clog2(EDGE_CAPACITY);
  localparam int CW = $clog2(EDGE_CAPACITY + 1);

  // head entry: {present, first edge}
  localparam int HEAD_W = 1 + EW;
  // edge entry: {target, link valid, link}
  localparam int EDGE_W = VERTEX_W + 1 + EW;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLR   = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_QHEAD = 3'd3;
  localparam logic [2:0] S_QWALK = 3'd4;
  localparam logic [2:0] S_RES   = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [VW-1:0] sweep_r, sweep_nxt;
  logic          pend_r, pend_nxt;     // clear item owes a result after sweep
  logic [CW-1:0] used_r, used_nxt;     // edge entries in use
  opcode_t       op_r, op_nxt;
  logic [VW-1:0] src_r, src_nxt;
  vertex_t       dst_r, dst_nxt;
  logic          found_r, found_nxt;
  logic          ovf_r, ovf_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_is_answer_r, out_is_answer_nxt;
  logic          out_edge_found_r, out_edge_found_nxt;
  logic          out_overflow_r, out_overflow_nxt;

  // RAM ports
  logic              head_we;
  logic [VW-1:0]     head_waddr, head_raddr;
  logic [HEAD_W-1:0] head_wdata, head_rdata;
  logic              edge_we;
  logic [EW-1:0]     edge_waddr, edge_raddr;
  logic [EDGE_W-1:0] edge_wdata, edge_rdata;

  // input decode
  logic [VW+VERTEX_W-1:0] src_wide;
  logic [VW-1:0]          src_addr;
  logic                   src_in_range;
  logic                   store_full;
  logic                   in_fire;

  assign src_wide     = {{VW{1'b0}}, in_from_vertex};
  assign src_addr     = src_wide[VW-1:0];
  assign src_in_range = ({1'b0, src_wide} < (VW + VERTEX_W + 1)'(VERTEX_COUNT));
  assign store_full   = (used_r == CW'(EDGE_CAPACITY));

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // head of list per vertex
  ales_ram #(
    .WIDTH (HEAD_W),
    .DEPTH (VERTEX_COUNT)
  ) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (head_raddr),
    .rdata (head_rdata)
  );

  // edge entries, allocated in order
  ales_ram #(
    .WIDTH (EDGE_W),
    .DEPTH (EDGE_CAPACITY)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  always_comb begin
    state_nxt          = state_r;
    sweep_nxt          = sweep_r;
    pend_nxt           = pend_r;
    used_nxt           = used_r;
    op_nxt             = op_r;
    src_nxt            = src_r;
    dst_nxt            = dst_r;
    found_nxt          = found_r;
    ovf_nxt            = ovf_r;
    out_valid_nxt      = out_valid_r;
    out_is_answer_nxt  = out_is_answer_r;
    out_edge_found_nxt = out_edge_found_r;
    out_overflow_nxt   = out_overflow_r;

    head_we    = 1'b0;
    head_waddr = src_r;
    head_wdata = '0;
    head_raddr = src_addr;           // head read starts as the item is taken
    edge_we    = 1'b0;
    edge_waddr = used_r[EW-1:0];
    edge_wdata = {dst_r, head_rdata[EW], head_rdata[EW-1:0]};
    edge_raddr = head_rdata[EW-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        // mark every list absent, one vertex a cycle
        head_we    = 1'b1;
        head_waddr = sweep_r;
        head_wdata = '0;
        if (sweep_r == VW'(VERTEX_COUNT - 1)) begin
          sweep_nxt = '0;
          pend_nxt  = 1'b0;
          state_nxt = pend_r ? S_RES : S_IDLE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          src_nxt   = src_addr;
          dst_nxt   = in_to_vertex;
          found_nxt = 1'b0;
          ovf_nxt   = 1'b0;
          case (in_opcode)
            OP_CLEAR: begin
              used_nxt  = '0;
              pend_nxt  = 1'b1;
              state_nxt = S_CLR;
            end
            OP_ADD: begin
              if (!src_in_range) begin
                state_nxt = S_RES;
              end else if (store_full) begin
                ovf_nxt   = 1'b1;
                state_nxt = S_RES;
              end else begin
                state_nxt = S_ADD;
              end
            end
            OP_QUERY: begin
              state_nxt = src_in_range ? S_QHEAD : S_RES;
            end
            default: begin
              state_nxt = S_RES;
            end
          endcase
        end
      end
      S_ADD: begin
        // new entry links to old head (if any) and becomes the head
        edge_we    = 1'b1;
        head_we    = 1'b1;
        head_waddr = src_r;
        head_wdata = {1'b1, used_r[EW-1:0]};
        used_nxt   = used_r + 1'b1;
        state_nxt  = S_RES;
      end
      S_QHEAD: begin
        edge_raddr = head_rdata[EW-1:0];
        state_nxt  = head_rdata[EW] ? S_QWALK : S_RES;
      end
      S_QWALK: begin
        edge_raddr = edge_rdata[EW-1:0];
        if (edge_rdata[EDGE_W-1 -: VERTEX_W] == dst_r) begin
          found_nxt = 1'b1;
          state_nxt = S_RES;
        end else if (!edge_rdata[EW]) begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          out_is_answer_nxt  = (op_r == OP_QUERY);
          out_edge_found_nxt = found_r;
          out_overflow_nxt   = ovf_r;
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      sweep_r     <= '0;
      pend_r      <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      pend_r      <= pend_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r             <= op_nxt;
    src_r            <= src_nxt;
    dst_r            <= dst_nxt;
    found_r          <= found_nxt;
    ovf_r            <= ovf_nxt;
    out_is_answer_r  <= out_is_answer_nxt;
    out_edge_found_r <= out_edge_found_nxt;
    out_overflow_r   <= out_overflow_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_is_answer  = out_is_answer_r;
  assign out_edge_found = out_edge_found_r;
  assign out_overflow   = out_overflow_r;

  // fill count never passes capacity
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(EDGE_CAPACITY))
    else $error("edge fill count beyond capacity");

  // clear frees the whole store at once
  a_clear_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_opcode == OP_CLEAR) |=> (used_r == '0))
    else $error("clear did not free edge store");

  // a stored edge takes exactly one entry
  a_add_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_opcode == OP_ADD && src_in_range && !store_full) |=>
      ##1 (used_r == $past(used_r, 2) + 1'b1))
    else $error("add did not allocate one entry");

  // walk never runs while head sweep is pending
  a_walk_no_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QWALK) |-> !pend_r)
    else $error("list walk during clear");

endmodule

`default_nettype wire

>>> rtl/ales_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// simple dual-port RAM, one write port, one registered read port
module ales_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ales_pkg::*;

  localparam int VERTEX_COUNT  = 1024;
  localparam int EDGE_CAPACITY = 4096;

  // Opcode 3 has no meaning in the block; it must give an all-zero result.
  localparam opcode_t OP_UNUSED = 2'd3;

  // Sizing for the fill phase: edges spread over a handful of source vertices
  // so each list is some tens of entries long.
  localparam int FILL_SOURCES = 4;
  localparam int FILL_EDGES   = 256;

  // Receiver backpressure: one long hold-off once this many results are in.
  localparam int PRESSURE_AT    = 300;
  localparam int PRESSURE_HOLD  = 400;
  localparam int RANDOM_ITEMS   = 600;
  localparam int DRAIN_CYCLES   = 40;
  localparam int CYCLE_LIMIT    = 1500000;

  // One result item, in port order.
  typedef struct packed {
    logic is_answer;
    logic edge_found;
    logic overflow;
  } edge_result_t;

  // Predicts each result from its own copy of the edge store and checks
  // the block's results against it in order.
  class edge_store_scoreboard;
    bit           present   [VERTEX_COUNT];
    int unsigned  head      [VERTEX_COUNT];
    vertex_t      target    [EDGE_CAPACITY];
    int unsigned  link      [EDGE_CAPACITY];
    bit           link_ok   [EDGE_CAPACITY];
    int unsigned  edges_used;
    edge_result_t answers_due [$];
    int unsigned  mismatches;

    function new();
      wipe();
      mismatches = 0;
    endfunction

    // Only present and the fill count matter; the rest is guarded.
    function void wipe();
      foreach (present[i]) present[i] = 1'b0;
      edges_used = 0;
    endfunction

    function void note_item(opcode_t op, vertex_t src, vertex_t dst);
      edge_result_t r;
      int unsigned  slot;
      int unsigned  cur;
      int unsigned  visited;
      bit           more;
      r = '0;
      case (op)
        OP_CLEAR: begin
          wipe();
        end
        OP_ADD: begin
          if (int'(src) < VERTEX_COUNT) begin
            if (edges_used >= EDGE_CAPACITY) begin
              r.overflow = 1'b1;
            end else begin
              // new entry goes in front of the list
              slot          = edges_used;
              edges_used++;
              target[slot]  = dst;
              link_ok[slot] = present[src];
              link[slot]    = head[src];
              present[src]  = 1'b1;
              head[src]     = slot;
            end
          end
        end
        OP_QUERY: begin
          r.is_answer = 1'b1;
          if (int'(src) < VERTEX_COUNT && present[src]) begin
            cur     = head[src];
            more    = 1'b1;
            visited = 0;
            // walk is bounded by the number of entries in use
            while (more && visited < edges_used && !r.edge_found) begin
              if (target[cur] == dst) begin
                r.edge_found = 1'b1;
              end else begin
                more = link_ok[cur];
                cur  = link[cur];
              end
              visited++;
            end
          end
        end
        default: ;
      endcase
      answers_due.push_back(r);
    endfunction

    function void flag(string field, logic want, logic got);
      mismatches++;
      $display("%0t: %s expected %0b actual %0b", $time, field, want, got);
    endfunction

    function void check_result(edge_result_t got);
      edge_result_t want;
      if (answers_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected, expected none actual %b", $time, got);
        return;
      end
      want = answers_due.pop_front();
      if (got.is_answer !== want.is_answer)
        flag("is_answer", want.is_answer, got.is_answer);
      if (got.edge_found !== want.edge_found)
        flag("edge_found", want.edge_found, got.edge_found);
      if (got.overflow !== want.overflow)
        flag("overflow", want.overflow, got.overflow);
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst_n;
  logic    in_valid;
  logic    in_ready;
  opcode_t in_opcode;
  vertex_t in_from_vertex;
  vertex_t in_to_vertex;
  logic    out_valid;
  logic    out_ready;
  logic    out_is_answer;
  logic    out_edge_found;
  logic    out_overflow;

  edge_store_scoreboard sb;
  int unsigned          cycles = 0;
  int unsigned          results_seen = 0;

  adjacency_list_edge_store #(
    .VERTEX_COUNT  (VERTEX_COUNT),
    .EDGE_CAPACITY (EDGE_CAPACITY)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_from_vertex (in_from_vertex),
    .in_to_vertex   (in_to_vertex),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_is_answer  (out_is_answer),
    .out_edge_found (out_edge_found),
    .out_overflow   (out_overflow)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: far above the slowest legal run (reset sweep, list fill,
  // long walks after the fill, clears, worst-case gaps on both sides).
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Idle cycles after an item; calm stretches give back-to-back traffic.
  function automatic int unsigned pick_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // Mostly a small set of hot vertices so lists grow and queries hit;
  // otherwise anything in the 10-bit range.
  function automatic vertex_t pick_vertex();
    if ($urandom_range(0, 9) >= 7) return vertex_t'($urandom_range(0, 1023));
    case ($urandom_range(0, 7))
      0:       return vertex_t'(0);
      1:       return vertex_t'(1023);
      2:       return vertex_t'(1);
      3:       return vertex_t'(512);
      4:       return vertex_t'(341);
      5:       return vertex_t'(682);
      6:       return vertex_t'(7);
      default: return vertex_t'(1000);
    endcase
  endfunction

  // Offer one item, hold it until taken, then idle for gap cycles. With a
  // zero gap valid stays high so the next call just swaps the payload.
  task automatic send_item(opcode_t op, vertex_t src, vertex_t dst, int unsigned gap);
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_from_vertex <= src;
    in_to_vertex   <= dst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(op, src, dst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side: values are read right after the edge, i.e. as the block
  // saw them at that edge. A hold-off lowers out_ready for a drawn number of
  // cycles; once in the run it is a long one so the block backs up.
  initial begin : receiver
    int unsigned hold;
    bit          calm;
    bit          pressed;
    hold      = 0;
    calm      = 1'b0;
    pressed   = 1'b0;
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        if (hold == 0) out_ready <= 1'b1;
      end else if (out_valid && out_ready) begin
        sb.check_result({out_is_answer, out_edge_found, out_overflow});
        results_seen++;
        if ($urandom_range(0, 39) == 0) calm = !calm;
        hold = pick_wait(calm);
        if (!pressed && results_seen >= PRESSURE_AT) begin
          pressed = 1'b1;
          hold    = PRESSURE_HOLD;
        end
        if (hold > 0) out_ready <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int unsigned  r;
    int unsigned  k;
    bit           calm;
    opcode_t      op;
    vertex_t      src;
    vertex_t      dst;
    vertex_t      tail_target [FILL_SOURCES];
    bit           source_used [FILL_SOURCES];

    sb = new();
    calm           = 1'b0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_opcode      <= OP_CLEAR;
    in_from_vertex <= '0;
    in_to_vertex   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty graph, vertex extremes, duplicates, unused opcode,
    // a vertex with no list, and a clear followed by reuse.
    send_item(OP_QUERY,  10'd0,    10'd0,    pick_wait(calm));
    send_item(OP_QUERY,  10'd1023, 10'd1023, pick_wait(calm));
    send_item(OP_UNUSED, 10'd1023, 10'd1023, pick_wait(calm));
    send_item(OP_ADD,    10'd0,    10'd1023, pick_wait(calm));
    send_item(OP_ADD,    10'd1023, 10'd0,    pick_wait(calm));
    send_item(OP_ADD,    10'd0,    10'd0,    pick_wait(calm));
    send_item(OP_ADD,    10'd0,    10'd0,    pick_wait(calm));
    send_item(OP_ADD,    10'd1023, 10'd1023, pick_wait(calm));
    send_item(OP_QUERY,  10'd0,    10'd1023, pick_wait(calm));
    send_item(OP_QUERY,  10'd0,    10'd0,    pick_wait(calm));
    send_item(OP_QUERY,  10'd0,    10'd5,    pick_wait(calm));
    send_item(OP_QUERY,  10'd1023, 10'd0,    pick_wait(calm));
    send_item(OP_QUERY,  10'd1023, 10'd1023, pick_wait(calm));
    send_item(OP_QUERY,  10'd5,    10'd0,    pick_wait(calm));
    send_item(OP_ADD,    10'd512,  10'd341,  pick_wait(calm));
    send_item(OP_QUERY,  10'd512,  10'd682,  pick_wait(calm));
    send_item(OP_QUERY,  10'd512,  10'd341,  pick_wait(calm));
    send_item(OP_CLEAR,  10'd1023, 10'd1023, pick_wait(calm));
    send_item(OP_QUERY,  10'd0,    10'd1023, pick_wait(calm));
    send_item(OP_ADD,    10'd0,    10'd1,    pick_wait(calm));
    send_item(OP_QUERY,  10'd0,    10'd1023, pick_wait(calm));
    send_item(OP_QUERY,  10'd0,    10'd1,    pick_wait(calm));
    send_item(OP_UNUSED, 10'd0,    10'd0,    pick_wait(calm));

    // Build a few long lists, then add further edges. Queries for the
    // oldest entry of each list walk the whole list.
    send_item(OP_CLEAR, 10'd0, 10'd0, pick_wait(calm));
    foreach (source_used[i]) source_used[i] = 1'b0;
    for (int n = 0; n < FILL_EDGES; n++) begin
      k   = $urandom_range(0, FILL_SOURCES - 1);
      src = vertex_t'(k * 64 + 5);
      dst = vertex_t'($urandom_range(0, 1023));
      if (!source_used[k]) begin
        source_used[k] = 1'b1;
        tail_target[k] = dst;
      end
      send_item(OP_ADD, src, dst, pick_wait(calm));
    end
    send_item(OP_ADD, 10'd5,  10'd9, pick_wait(calm));
    send_item(OP_ADD, 10'd3,  10'd9, pick_wait(calm));
    send_item(OP_ADD, 10'd3,  10'd9, pick_wait(calm));
    send_item(OP_QUERY, 10'd3, 10'd9, pick_wait(calm));
    for (int i = 0; i < FILL_SOURCES; i++) begin
      if (source_used[i]) begin
        src = vertex_t'(i * 64 + 5);
        send_item(OP_QUERY, src, tail_target[i], pick_wait(calm));
        send_item(OP_QUERY, src, vertex_t'($urandom_range(0, 1023)), pick_wait(calm));
      end
    end
    send_item(OP_CLEAR, 10'd0, 10'd0, pick_wait(calm));

    // Random traffic: adds and queries on hot vertices, occasional clears
    // (which keep lists short) and the odd unused opcode.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      r = $urandom_range(0, 99);
      if (r < 3)       op = OP_CLEAR;
      else if (r < 6)  op = OP_UNUSED;
      else if (r < 52) op = OP_ADD;
      else             op = OP_QUERY;
      send_item(op, pick_vertex(), pick_vertex(), pick_wait(calm));
    end
    in_valid <= 1'b0;

    // Every item gives one result; after the last one, watch a little
    // longer for anything stray.
    while (sb.answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
